@@ rtl/core/amst_pkg.sv @@
package amst_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COST_W     = 42;
  localparam int DIST_W     = 33;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_INF = '1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PICK0,
    ST_PICK1,
    ST_SCAN0,
    ST_SCAN1,
    ST_SCAN2,
    ST_SCAN3,
    ST_SCAN4,
    ST_OUT
  } state_t;

  // sign-extend from COORD_BITS-1, then flip the top bit so unsigned order matches
  function automatic logic [31:0] to_biased(input logic [31:0] raw);
    logic [31:0] v;
    v = raw;
    for (int b = COORD_BITS; b < 32; b++) begin
      v[b] = raw[COORD_BITS-1];
    end
    return v ^ 32'h8000_0000;
  endfunction

endpackage

@@ rtl/core/axis_gap_kruskal_mst.sv @@
// channel | ports                                   | direction
// in      | in_valid, in_stall, coord_x/y/z, last_point | request into the block
// out     | out_valid, out_stall, total_cost, overflow_flag | result from the block
// Points load at one per cycle. After the last point the tree is grown one point
// at a time over the stored set: each growth step scans every point through one
// shared gap/min unit, and the result is offered once every stored point is in
// the tree. Input is stalled from the last point until its result is taken.
// Reset is synchronous; the coordinate and distance memories need no clearing.
module axis_gap_kruskal_mst
  import amst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        coord_x,
  input  logic [31:0]        coord_y,
  input  logic [31:0]        coord_z,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COST_W-1:0]  total_cost,
  output logic               overflow_flag
);

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [COST_W-1:0] cost;
  logic [31:0]       ux, uy, uz;
  logic [IDX_W-1:0]  u_idx;
  logic [DIST_W-1:0] bestd;
  logic [IDX_W-1:0]  bestj;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  tree_size;
  logic              first;
  logic [DIST_W-1:0] acc;

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_z [MAX_POINTS];
  logic [32:0] dist_mem [MAX_POINTS];
  logic [31:0] rx, ry, rz;
  logic [32:0] dist_rd;

  logic             accept;
  logic             store_we;
  logic [IDX_W-1:0] rd_addr;
  logic             dist_we;
  logic [IDX_W-1:0] dist_addr;
  logic [32:0]      dist_wdata;

  logic [31:0]       unit_a, unit_b;
  logic [DIST_W-1:0] unit_acc, unit_res;

  logic              intree;
  logic [DIST_W-1:0] old_d, new_d;
  logic [COST_W:0]   cost_sum;

  assign accept   = in_valid & ~in_stall;
  assign store_we = accept & (count < CNT_W'(MAX_POINTS));

  assign intree   = first ? (j[IDX_W-1:0] == u_idx) : dist_rd[32];
  assign old_d    = first ? DIST_INF : {1'b0, dist_rd[31:0]};
  assign new_d    = (acc < old_d) ? acc : old_d;
  assign cost_sum = {1'b0, cost} + (COST_W+1)'(bestd);

  amst_unit u_unit (
    .a   (unit_a),
    .b   (unit_b),
    .acc (unit_acc),
    .res (unit_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (accept && last_point) state_next = ST_PICK0;
      ST_PICK0: state_next = ST_PICK1;
      ST_PICK1: state_next = (tree_size == count) ? ST_OUT : ST_SCAN0;
      ST_SCAN0: state_next = ST_SCAN1;
      ST_SCAN1: state_next = ST_SCAN2;
      ST_SCAN2: state_next = ST_SCAN3;
      ST_SCAN3: state_next = ST_SCAN4;
      ST_SCAN4: state_next = (j + 1'b1 == count) ? ST_PICK0 : ST_SCAN0;
      ST_OUT:   if (!out_stall) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs and datapath steering
  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    rd_addr    = j[IDX_W-1:0];
    dist_we    = 1'b0;
    dist_addr  = j[IDX_W-1:0];
    dist_wdata = {intree, intree ? old_d[31:0] : new_d[31:0]};
    unit_a     = rx;
    unit_b     = ux;
    unit_acc   = DIST_INF;
    case (state)
      ST_LOAD: in_stall = 1'b0;
      ST_PICK0: begin
        rd_addr    = bestj;
        dist_we    = 1'b1;
        dist_addr  = bestj;
        dist_wdata = {1'b1, 32'd0};
      end
      ST_SCAN2: begin
        unit_a   = ry;
        unit_b   = uy;
        unit_acc = acc;
      end
      ST_SCAN3: begin
        unit_a   = rz;
        unit_b   = uz;
        unit_acc = acc;
      end
      ST_SCAN4: dist_we = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign total_cost    = cost;
  assign overflow_flag = dropped;

  always_ff @(posedge clk) begin
    if (store_we) begin
      mem_x[count[IDX_W-1:0]] <= to_biased(coord_x);
      mem_y[count[IDX_W-1:0]] <= to_biased(coord_y);
      mem_z[count[IDX_W-1:0]] <= to_biased(coord_z);
    end
    rx <= mem_x[rd_addr];
    ry <= mem_y[rd_addr];
    rz <= mem_z[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_addr] <= dist_wdata;
    end
    if (state == ST_SCAN0) begin
      dist_rd <= dist_mem[j[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      cost      <= '0;
      first     <= 1'b0;
      tree_size <= '0;
      j         <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (store_we) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (last_point) begin
              bestd     <= '0;
              bestj     <= '0;
              tree_size <= '0;
              first     <= 1'b1;
              cost      <= '0;
            end
          end
        end
        ST_PICK0: begin
          u_idx     <= bestj;
          tree_size <= tree_size + 1'b1;
          // saturate the running cost
          cost      <= (cost_sum > {1'b0, COST_MAX}) ? COST_MAX : cost_sum[COST_W-1:0];
        end
        ST_PICK1: begin
          ux    <= rx;
          uy    <= ry;
          uz    <= rz;
          j     <= '0;
          bestd <= DIST_INF;
        end
        ST_SCAN1, ST_SCAN2, ST_SCAN3: acc <= unit_res;
        ST_SCAN4: begin
          if (!intree && new_d < bestd) begin
            bestd <= new_d;
            bestj <= j[IDX_W-1:0];
          end
          j <= j + 1'b1;
          if (j + 1'b1 == count) begin
            first <= 1'b0;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            count   <= '0;
            dropped <= 1'b0;
            cost    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/amst_unit.sv @@
module amst_unit
  import amst_pkg::*;
(
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [DIST_W-1:0] acc,
  output logic [DIST_W-1:0] res
);

  logic [31:0]       gap;
  logic [DIST_W-1:0] gap_ext;

  assign gap     = (a >= b) ? (a - b) : (b - a);
  assign gap_ext = {1'b0, gap};
  assign res     = (gap_ext < acc) ? gap_ext : acc;

endmodule

@@ sim/mst_cost_checker.sv @@
module mst_cost_checker
  import amst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [31:0]       coord_x,
  input  logic [31:0]       coord_y,
  input  logic [31:0]       coord_z,
  input  logic              last_point,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [COST_W-1:0] total_cost,
  input  logic              overflow_flag,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]       px [MAX_POINTS];
  logic [31:0]       py [MAX_POINTS];
  logic [31:0]       pz [MAX_POINTS];
  int                stored;
  logic              dropped;
  logic [COST_W-1:0] cost_due [$];
  logic              flag_due [$];
  int                errs;

  function automatic logic [DIST_W-1:0] abs_gap(logic [31:0] a, logic [31:0] b);
    return (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, b} - {1'b0, a};
  endfunction

  // weight of a pair: smallest gap over the three axes (same tree cost as
  // Kruskal over the axis-neighbour edges)
  function automatic logic [DIST_W-1:0] pair_weight(int i, int j);
    logic [DIST_W-1:0] g;
    logic [DIST_W-1:0] h;
    g = abs_gap(px[i], px[j]);
    h = abs_gap(py[i], py[j]);
    if (h < g) g = h;
    h = abs_gap(pz[i], pz[j]);
    if (h < g) g = h;
    return g;
  endfunction

  function automatic logic [COST_W-1:0] tree_cost(int n);
    bit                in_tree [MAX_POINTS];
    logic [DIST_W-1:0] best [MAX_POINTS];
    logic [COST_W:0]   sum;
    logic [DIST_W-1:0] w;
    logic [DIST_W-1:0] low;
    int                cur;
    int                nxt;
    sum = '0;
    if (n < 2) return '0;
    for (int j = 0; j < n; j++) begin
      in_tree[j] = 0;
      best[j] = DIST_INF;
    end
    in_tree[0] = 1;
    cur = 0;
    for (int k = 1; k < n; k++) begin
      nxt = -1;
      low = DIST_INF;
      for (int j = 0; j < n; j++) begin
        if (!in_tree[j]) begin
          w = pair_weight(cur, j);
          if (w < best[j]) best[j] = w;
          if (nxt < 0 || best[j] < low) begin
            low = best[j];
            nxt = j;
          end
        end
      end
      in_tree[nxt] = 1;
      sum += low;
      if (sum > COST_MAX) sum = COST_MAX;
      cur = nxt;
    end
    return sum[COST_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored = 0;
      dropped = 1'b0;
      fails <= 0;
    end else begin
      errs = 0;
      if (in_valid && !in_stall) begin
        if (stored < MAX_POINTS) begin
          px[stored] = to_biased(coord_x);
          py[stored] = to_biased(coord_y);
          pz[stored] = to_biased(coord_z);
          stored = stored + 1;
        end else begin
          dropped = 1'b1;
        end
        if (last_point) begin
          cost_due = {cost_due, tree_cost(stored)};
          flag_due = {flag_due, dropped};
          stored = 0;
          dropped = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (cost_due.size() == 0) begin
          $error("result with nothing expected: total_cost %0d", total_cost);
          errs = errs + 1;
        end else begin
          if (total_cost !== cost_due[0]) begin
            $error("total_cost: expected %0d, actual %0d", cost_due[0], total_cost);
            errs = errs + 1;
          end
          if (overflow_flag !== flag_due[0]) begin
            $error("overflow_flag: expected %0d, actual %0d", flag_due[0], overflow_flag);
            errs = errs + 1;
          end
          void'(cost_due.pop_front());
          void'(flag_due.pop_front());
        end
      end
      fails <= fails + errs;
    end
    pending = cost_due.size();
  end

endmodule

@@ sim/axis_gap_kruskal_mst_tb.sv @@
module axis_gap_kruskal_mst_tb;
  import amst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [31:0]       coord_x = '0;
  logic [31:0]       coord_y = '0;
  logic [31:0]       coord_z = '0;
  logic              last_point = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [COST_W-1:0] total_cost;
  logic              overflow_flag;
  int                fails;
  int                pending;
  int                sets_sent;
  int                points_sent;
  int                burst_left;
  int                taken = 0;

  always #5 clk = ~clk;

  axis_gap_kruskal_mst i_dut (.*);

  mst_cost_checker i_check (.*);

  // receiver: random stalls with stall-free stretches, one long hold-off after five results
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold = hold - 1;
      end else if (!held && taken == 5) begin
        out_stall <= 1'b1;
        hold = 400;
        held = 1'b1;
      end else if ((taken / 3) % 2 == 1) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) taken <= taken + 1;
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent = points_sent + 1;
    if (last) sets_sent = sets_sent + 1;
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 3) << 30;
    endcase
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
  endtask

  initial begin
    sets_sent = 0;
    points_sent = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single point, then the two corners of the coordinate space
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    // identical points cost nothing
    send_point(32'h1234_5678, 32'hffff_ffff, 32'h5555_aaaa, 1'b0);
    send_point(32'h1234_5678, 32'hffff_ffff, 32'h5555_aaaa, 1'b0);
    send_point(32'h1234_5678, 32'hffff_ffff, 32'h5555_aaaa, 1'b1);
    // ties in weight on several axes
    send_point(32'd0, 32'd10, 32'd20, 1'b0);
    send_point(32'd10, 32'd0, 32'd20, 1'b0);
    send_point(32'd20, 32'd10, 32'd0, 1'b0);
    send_point(-32'sd10, 32'd20, 32'd10, 1'b1);
    send_set(6, 2);
    send_set(5, 3);

    // capacity: fill the store, then drop two more including the last one
    send_set(MAX_POINTS + 2, 1);
    send_point(32'd1, 32'd2, 32'd3, 1'b1);
    send_set(3, 0);

    while (points_sent < 450 + MAX_POINTS + 2) begin
      if ($urandom_range(0, 9) == 0) send_set($urandom_range(13, 30), $urandom_range(0, 3));
      else send_set($urandom_range(1, 12), $urandom_range(0, 3));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d point sets (%0d points) covered, incl. extremes, ties and a dropped set",
             sets_sent, points_sent);
    if (fails == 0) begin
      $display("axis_gap_kruskal_mst: match");
    end else begin
      $display("axis_gap_kruskal_mst: mismatch");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("axis_gap_kruskal_mst: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/amst_pkg.sv
rtl/core/amst_unit.sv
rtl/core/axis_gap_kruskal_mst.sv
sim/mst_cost_checker.sv
sim/axis_gap_kruskal_mst_tb.sv
